FILE: design/hbsa_pkg.sv
// hbsa_pkg: widths, constants, status codes and result type for the heap block slot allocator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package hbsa_pkg;

	localparam int unsigned LEN_W  = 13;
	localparam int unsigned BLK_W  = 16;
	localparam int unsigned SLOT_W = 11;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned HDR_W  = 7;
	// wide enough for header + used + len + page map + pad at the largest values
	localparam int unsigned NEED_W = 16;

	localparam int unsigned BLOCK_DATA_BYTES_DEF = 8176;
	localparam int unsigned MAX_SLOTS_DEF        = 2047;

	localparam logic [HDR_W-1:0] HDR_FIRST  = HDR_W'(12);
	localparam logic [HDR_W-1:0] HDR_PAGE   = HDR_W'(2);
	localparam logic [HDR_W-1:0] HDR_BITMAP = HDR_W'(2 + 64);

	// page map for one slot (4 + 2*2) plus the alignment pad byte
	localparam int unsigned MAP_ONE_PAD = 4 + 2 * 2 + 1;

	localparam int unsigned BITMAP_PERIOD = 128;
	localparam int unsigned PERIOD_W      = $clog2(BITMAP_PERIOD);
	localparam logic [PERIOD_W-1:0] BITMAP_FIRST = PERIOD_W'(8);

	localparam logic [BLK_W-1:0] LAST_BLOCK = 16'hFFFF;

	typedef enum logic [STAT_W-1:0] {
		ST_PLACED   = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [BLK_W-1:0]   block_number;
		logic [SLOT_W-1:0]  slot_number;
		logic               block_closed;
	} res_t;

endpackage

FILE: design/hbsa_if.sv
// hbsa_if: valid/ready channel interfaces for request lengths and placement results.
// Depends on hbsa_pkg for field widths.
interface hbsa_len_if;
	logic                        valid;
	logic                        ready;
	logic [hbsa_pkg::LEN_W-1:0]  alloc_len;

	modport source (output valid, output alloc_len, input ready);
	modport sink   (input valid, input alloc_len, output ready);
endinterface

interface hbsa_res_if;
	logic                         valid;
	logic                         ready;
	logic [hbsa_pkg::STAT_W-1:0]  status;
	logic [hbsa_pkg::BLK_W-1:0]   block_number;
	logic [hbsa_pkg::SLOT_W-1:0]  slot_number;
	logic                         block_closed;

	modport source (output valid, output status, output block_number, output slot_number,
		output block_closed, input ready);
	modport sink   (input valid, input status, input block_number, input slot_number,
		input block_closed, output ready);
endinterface

FILE: design/heap_block_slot_allocator.sv
// heap_block_slot_allocator: top level with input register, placement logic and result register.
// Depends on hbsa_pkg, hbsa_if and hbsa_place.

// Takes one allocation length per item and returns one result item: status, block number,
// one-based slot and a flag marking that the previous rolling block was closed. With the
// result side ready, one item is accepted every cycle. An item waits in the input register
// while the fit compare against the state registers runs, and its result is then presented
// from the result register. While a result waits, one more item can be taken into the input
// register; after that the input stalls until the result is taken.
// Rejected items (too long, or block count overflow) leave the allocator state untouched.
module heap_block_slot_allocator #(
	parameter int unsigned BLOCK_DATA_BYTES = hbsa_pkg::BLOCK_DATA_BYTES_DEF,
	parameter int unsigned MAX_SLOTS        = hbsa_pkg::MAX_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hbsa_len_if.sink    req,
	hbsa_res_if.source  rsp
);

	logic                        valid_s1;
	logic [hbsa_pkg::LEN_W-1:0]  len_s1;
	logic                        out_valid_q;
	hbsa_pkg::res_t              out_q;
	hbsa_pkg::res_t              res;
	logic                        advance;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			len_s1 <= req.alloc_len;
		end
	end

	hbsa_place #(
		.BLOCK_DATA_BYTES (BLOCK_DATA_BYTES),
		.MAX_SLOTS        (MAX_SLOTS)
	) u_place (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.alloc_len (len_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.block_number = out_q.block_number;
	assign rsp.slot_number  = out_q.slot_number;
	assign rsp.block_closed = out_q.block_closed;

endmodule

FILE: design/hbsa_place.sv
// hbsa_place: allocator state registers and the combinational fit/placement decision.
// Depends on hbsa_pkg.
module hbsa_place #(
	parameter int unsigned BLOCK_DATA_BYTES = hbsa_pkg::BLOCK_DATA_BYTES_DEF,
	parameter int unsigned MAX_SLOTS        = hbsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [hbsa_pkg::LEN_W-1:0]  alloc_len,
	output hbsa_pkg::res_t              res
);

	localparam int unsigned LEN_LIMIT =
		BLOCK_DATA_BYTES - 66 - hbsa_pkg::MAP_ONE_PAD;

	logic [hbsa_pkg::LEN_W-1:0]  first_bytes_q;
	logic [hbsa_pkg::SLOT_W-1:0] first_slots_q;
	logic [hbsa_pkg::BLK_W-1:0]  roll_num_q;
	logic [hbsa_pkg::LEN_W-1:0]  roll_bytes_q;
	logic [hbsa_pkg::SLOT_W-1:0] roll_slots_q;

	logic [hbsa_pkg::LEN_W-1:0]  first_bytes_d;
	logic [hbsa_pkg::SLOT_W-1:0] first_slots_d;
	logic [hbsa_pkg::BLK_W-1:0]  roll_num_d;
	logic [hbsa_pkg::LEN_W-1:0]  roll_bytes_d;
	logic [hbsa_pkg::SLOT_W-1:0] roll_slots_d;

	logic                        too_long;
	logic                        in_first;
	logic                        first_fit;
	logic                        roll_fit;
	logic [hbsa_pkg::HDR_W-1:0]  roll_hdr;

	// header + used + len + page map for slots+1 + pad
	function automatic logic [hbsa_pkg::NEED_W-1:0] need_bytes(
		input logic [hbsa_pkg::HDR_W-1:0]  hdr,
		input logic [hbsa_pkg::LEN_W-1:0]  used,
		input logic [hbsa_pkg::SLOT_W-1:0] slots,
		input logic [hbsa_pkg::LEN_W-1:0]  len
	);
		return hbsa_pkg::NEED_W'(hdr) + hbsa_pkg::NEED_W'(used) + hbsa_pkg::NEED_W'(len)
			+ hbsa_pkg::NEED_W'({slots, 1'b0})
			+ hbsa_pkg::NEED_W'(hbsa_pkg::MAP_ONE_PAD);
	endfunction

	// bitmap blocks are 8, 136, 264, ...; block 0 never reaches this path
	assign roll_hdr = (roll_num_q[hbsa_pkg::PERIOD_W-1:0] == hbsa_pkg::BITMAP_FIRST)
		? hbsa_pkg::HDR_BITMAP : hbsa_pkg::HDR_PAGE;

	assign too_long  = hbsa_pkg::NEED_W'(alloc_len) > hbsa_pkg::NEED_W'(LEN_LIMIT);
	assign in_first  = (roll_num_q == '0);
	assign first_fit = (need_bytes(hbsa_pkg::HDR_FIRST, first_bytes_q, first_slots_q, alloc_len)
		<= hbsa_pkg::NEED_W'(BLOCK_DATA_BYTES))
		&& (first_slots_q < hbsa_pkg::SLOT_W'(MAX_SLOTS));
	assign roll_fit  = (need_bytes(roll_hdr, roll_bytes_q, roll_slots_q, alloc_len)
		<= hbsa_pkg::NEED_W'(BLOCK_DATA_BYTES))
		&& (roll_slots_q < hbsa_pkg::SLOT_W'(MAX_SLOTS));

	always_comb begin
		first_bytes_d    = first_bytes_q;
		first_slots_d    = first_slots_q;
		roll_num_d       = roll_num_q;
		roll_bytes_d     = roll_bytes_q;
		roll_slots_d     = roll_slots_q;
		res.status       = hbsa_pkg::ST_PLACED;
		res.block_number = '0;
		res.slot_number  = '0;
		res.block_closed = 1'b0;
		if (too_long) begin
			res.status = hbsa_pkg::ST_TOO_LONG;
		end else if (in_first && first_fit) begin
			first_bytes_d   = first_bytes_q + alloc_len;
			first_slots_d   = first_slots_q + 1'b1;
			res.slot_number = first_slots_d;
		end else if (in_first) begin
			// leaving block 0 opens block 1 without counting as a close
			roll_num_d       = hbsa_pkg::BLK_W'(1);
			roll_bytes_d     = alloc_len;
			roll_slots_d     = hbsa_pkg::SLOT_W'(1);
			res.block_number = roll_num_d;
			res.slot_number  = roll_slots_d;
		end else if (roll_fit) begin
			roll_bytes_d     = roll_bytes_q + alloc_len;
			roll_slots_d     = roll_slots_q + 1'b1;
			res.block_number = roll_num_q;
			res.slot_number  = roll_slots_d;
		end else if (roll_num_q == hbsa_pkg::LAST_BLOCK) begin
			res.status = hbsa_pkg::ST_OVERFLOW;
		end else begin
			roll_num_d       = roll_num_q + 1'b1;
			roll_bytes_d     = alloc_len;
			roll_slots_d     = hbsa_pkg::SLOT_W'(1);
			res.block_number = roll_num_d;
			res.slot_number  = roll_slots_d;
			res.block_closed = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_bytes_q <= '0;
			first_slots_q <= '0;
			roll_num_q    <= '0;
			roll_bytes_q  <= '0;
			roll_slots_q  <= '0;
		end else if (fire) begin
			first_bytes_q <= first_bytes_d;
			first_slots_q <= first_slots_d;
			roll_num_q    <= roll_num_d;
			roll_bytes_q  <= roll_bytes_d;
			roll_slots_q  <= roll_slots_d;
		end
	end

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res.status != hbsa_pkg::ST_PLACED) |=>
			$stable(roll_num_q) && $stable(roll_slots_q) && $stable(first_slots_q))
		else $error("rejected item changed allocator state");

	a_close_next: assert property (@(posedge clk) disable iff (!arst_n)
		res.block_closed |-> (res.block_number == roll_num_q + 1'b1) && !in_first)
		else $error("closed block not followed by the next block number");

	a_first_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!in_first |=> (roll_num_q != '0) && $stable(first_slots_q))
		else $error("block 0 reopened or changed after leaving it");

	a_first_slot_cap: assert property (@(posedge clk) disable iff (!arst_n)
		first_slots_q <= hbsa_pkg::SLOT_W'(MAX_SLOTS))
		else $error("block 0 slot count beyond limit");

endmodule

FILE: bench/hbsa_place_check.sv
// hbsa_place_check: watches the length and result channels of the slot allocator,
// predicts every placement on its own copy of the block state and compares field by field.
// Depends on hbsa_pkg and the channel interfaces in hbsa_if.
module hbsa_place_check (
	input  logic                       clk,
	input  logic                       arst_n,
	hbsa_len_if                        req,
	hbsa_res_if                        rsp,
	output int                         failures,
	output int                         outstanding,
	output logic [hbsa_pkg::BLK_W-1:0] open_block,
	output int                         headroom,
	output int                         n_placed,
	output int                         n_rejected,
	output int                         n_closed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEN_LIMIT = int'(hbsa_pkg::BLOCK_DATA_BYTES_DEF)
		- int'(hbsa_pkg::HDR_BITMAP) - int'(hbsa_pkg::MAP_ONE_PAD);

	logic [hbsa_pkg::LEN_W-1:0]  first_bytes, roll_bytes;
	logic [hbsa_pkg::SLOT_W-1:0] first_slots, roll_slots;
	logic [hbsa_pkg::BLK_W-1:0]  roll_blk;
	hbsa_pkg::res_t              awaited_placements[$];

	// bytes still free for one more item in the given block, -1 once the slot count is spent
	function automatic int room_left(input int blk, input int used, input int slots);
		int hdr;
		if (blk == 0) begin
			hdr = int'(hbsa_pkg::HDR_FIRST);
		end else if (blk >= int'(hbsa_pkg::BITMAP_FIRST) &&
			(blk - int'(hbsa_pkg::BITMAP_FIRST)) % int'(hbsa_pkg::BITMAP_PERIOD) == 0) begin
			hdr = int'(hbsa_pkg::HDR_BITMAP);
		end else begin
			hdr = int'(hbsa_pkg::HDR_PAGE);
		end
		if (slots >= int'(hbsa_pkg::MAX_SLOTS_DEF))
			return -1;
		// page map grown to slots+1 entries, plus the pad byte
		return int'(hbsa_pkg::BLOCK_DATA_BYTES_DEF) - hdr - used - (4 + 2 * (slots + 2)) - 1;
	endfunction

	assign open_block = roll_blk;
	assign headroom   = (roll_blk == '0)
		? room_left(0, int'(first_bytes), int'(first_slots))
		: room_left(int'(roll_blk), int'(roll_bytes), int'(roll_slots));

	task automatic place_request(input logic [hbsa_pkg::LEN_W-1:0] len,
		output hbsa_pkg::res_t r);
		bit closing;
		bit placed;
		r        = '0;
		r.status = hbsa_pkg::ST_PLACED;
		closing  = 1'b0;
		placed   = 1'b1;
		if (int'(len) > LEN_LIMIT) begin
			r.status = hbsa_pkg::ST_TOO_LONG;
		end else if (roll_blk == '0 &&
			room_left(0, int'(first_bytes), int'(first_slots)) >= int'(len)) begin
			first_bytes   = first_bytes + len;
			first_slots   = first_slots + 1'b1;
			r.slot_number = first_slots;
		end else begin
			if (roll_blk == '0) begin
				// leaving block 0 is not a close
				roll_blk   = hbsa_pkg::BLK_W'(1);
				roll_bytes = '0;
				roll_slots = '0;
			end else if (room_left(int'(roll_blk), int'(roll_bytes), int'(roll_slots))
				< int'(len)) begin
				if (roll_blk == hbsa_pkg::LAST_BLOCK) begin
					r.status = hbsa_pkg::ST_OVERFLOW;
					placed   = 1'b0;
				end else begin
					roll_blk   = roll_blk + 1'b1;
					roll_bytes = '0;
					roll_slots = '0;
					closing    = 1'b1;
				end
			end
			if (placed) begin
				roll_bytes     = roll_bytes + len;
				roll_slots     = roll_slots + 1'b1;
				r.block_number = roll_blk;
				r.slot_number  = roll_slots;
				r.block_closed = closing;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		hbsa_pkg::res_t want;
		hbsa_pkg::res_t got;
		bit             bad;
		if (!arst_n) begin
			first_bytes = '0;
			first_slots = '0;
			roll_blk    = '0;
			roll_bytes  = '0;
			roll_slots  = '0;
			awaited_placements.delete();
			failures    = 0;
			n_placed    = 0;
			n_rejected  = 0;
			n_closed    = 0;
			outstanding = 0;
		end else begin
			// results trail their items through the input and result registers, so pop before queueing
			if (rsp.valid && rsp.ready) begin
				got = {rsp.status, rsp.block_number, rsp.slot_number, rsp.block_closed};
				if (awaited_placements.size() == 0) begin
					$display("%0t: result with nothing awaited: status %0d block %0d slot %0d closed %0d",
						$time, got.status, got.block_number, got.slot_number, got.block_closed);
					failures++;
				end else begin
					want = awaited_placements.pop_front();
					bad  = 1'b0;
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
						bad = 1'b1;
					end
					if (got.block_number !== want.block_number) begin
						$display("%0t: block_number expected %0d, got %0d", $time,
							want.block_number, got.block_number);
						bad = 1'b1;
					end
					if (got.slot_number !== want.slot_number) begin
						$display("%0t: slot_number expected %0d, got %0d", $time,
							want.slot_number, got.slot_number);
						bad = 1'b1;
					end
					if (got.block_closed !== want.block_closed) begin
						$display("%0t: block_closed expected %0d, got %0d", $time,
							want.block_closed, got.block_closed);
						bad = 1'b1;
					end
					if (bad)
						failures++;
					if (want.status == hbsa_pkg::ST_PLACED)
						n_placed++;
					else
						n_rejected++;
					if (want.block_closed)
						n_closed++;
				end
			end
			if (req.valid && req.ready) begin
				place_request(req.alloc_len, want);
				awaited_placements = {awaited_placements, want};
			end
			outstanding = awaited_placements.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// testbench: clock, reset and request stimulus for heap_block_slot_allocator, with random
// idling on both channels; checking is done by hbsa_place_check beside the block.
// Depends on hbsa_pkg, hbsa_if, hbsa_place_check and the block itself.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEN_LIMIT    = int'(hbsa_pkg::BLOCK_DATA_BYTES_DEF)
		- int'(hbsa_pkg::HDR_BITMAP) - int'(hbsa_pkg::MAP_ONE_PAD);
	localparam int LEN_TOP      = int'(hbsa_pkg::BLOCK_DATA_BYTES_DEF);
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 1200;
	localparam int RUSH_ITEMS   = 210;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	bit   rush = 1'b0;
	int   idle_cycles = 0;

	int                         failures, outstanding, headroom;
	int                         n_placed, n_rejected, n_closed;
	logic [hbsa_pkg::BLK_W-1:0] open_block;

	hbsa_len_if req_ch ();
	hbsa_res_if rsp_ch ();

	heap_block_slot_allocator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	hbsa_place_check place_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.failures    (failures),
		.outstanding (outstanding),
		.open_block  (open_block),
		.headroom    (headroom),
		.n_placed    (n_placed),
		.n_rejected  (n_rejected),
		.n_closed    (n_closed)
	);

	always #4 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// aims at the exact fit and one past it, as well as plain random lengths
	function automatic int random_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25 && headroom >= 0 && headroom <= LEN_LIMIT)
			return headroom;
		if (pick < 35 && headroom < LEN_LIMIT)
			return headroom + 1;
		if (pick < 45)
			return $urandom_range(LEN_LIMIT + 1, LEN_TOP);
		if (pick < 80)
			return $urandom_range(0, 300);
		return $urandom_range(0, LEN_LIMIT);
	endfunction

	task automatic pause(input int n);
		if (n > 0) begin
			req_ch.valid     <= 1'b0;
			req_ch.alloc_len <= hbsa_pkg::LEN_W'($urandom);
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_len(input int len);
		req_ch.valid     <= 1'b1;
		req_ch.alloc_len <= hbsa_pkg::LEN_W'(len);
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		if (!rush && $urandom_range(0, 99) == 0)
			calm = !calm;
		pause((calm || rush) ? 0 : gap_len());
	endtask

	initial begin : result_side
		int hold;
		hold         = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!calm && !rush && $urandom_range(0, 99) < 25)
					hold = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("[heap_block_slot_allocator] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.alloc_len = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// block 0: small items and over-long rejects at the boundary and the top
		send_len(0);
		send_len(LEN_TOP);
		send_len(1);
		send_len(LEN_LIMIT + 1);
		send_len(255);
		send_len(256);
		send_len(512);
		send_len(LEN_LIMIT);       // leaves block 0 for block 1, not a close
		send_len(headroom);        // exact fit
		send_len(0);               // no room left, closes block 1
		// march on to the first bitmap block, which takes the longest item exactly
		while (open_block < 8)
			send_len(LEN_LIMIT);
		send_len(0);

		repeat (RANDOM_ITEMS)
			send_len(random_len());

		// back to back on both channels, result side always ready
		rush = 1'b1;
		repeat (RUSH_ITEMS)
			send_len(random_len());
		rush = 1'b0;

		send_len(headroom);
		send_len(0);
		send_len(LEN_LIMIT);
		send_len(LEN_TOP);
		repeat (20)
			send_len(random_len());

		req_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run placed %0d items up to block %0d, with %0d rolling block closes",
			n_placed, open_block, n_closed);
		$display("and %0d rejected requests, under random and back-to-back timing.", n_rejected);
		if (failures == 0 && outstanding == 0)
			$display("[heap_block_slot_allocator] OK");
		else
			$display("[heap_block_slot_allocator] ERROR");
		$finish;
	end

endmodule

FILE: heap_block_slot_allocator.f
design/hbsa_pkg.sv
design/hbsa_if.sv
design/hbsa_place.sv
design/heap_block_slot_allocator.sv
bench/hbsa_place_check.sv
bench/testbench.sv
